FILE: hw/rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the traffic signal sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LAMP_N     = 4;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned LEN_W      = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_DURATION   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMP_COUNT = 1'b1;

  localparam logic [LEN_W-1:0]  PHASE_UNIT_MS  = LEN_W'(1700);
  localparam logic [TIME_W-1:0] BRAKE_ON_MS    = TIME_W'(1000);
  localparam logic [TIME_W-1:0] RED_AFTER_MS   = TIME_W'(3000);
  localparam logic [TIME_W-1:0] BRAKE_OFF_MS   = TIME_W'(2000);

  localparam logic [PHASE_W-1:0] PHASE_CODE_GREEN  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_CODE_YELLOW = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_CODE_RED    = 2'd2;

  localparam int unsigned LAMP_GREEN  = 0;
  localparam int unsigned LAMP_YELLOW = 1;
  localparam int unsigned LAMP_RED    = 2;
  localparam int unsigned LAMP_BRAKE  = 3;

  typedef enum logic [1:0] {
    FUNC_HEARTBEAT = 2'd0,
    FUNC_ON        = 2'd1,
    FUNC_OFF       = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    PH_GREEN  = 3'b001,
    PH_YELLOW = 3'b010,
    PH_RED    = 3'b100
  } phase_e;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LAMP_N-1:0]  lamps;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tss_core.sv
// ----------------------------------------------------------------------------
// tss_core
// Signal state, configuration registers and the per-request update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tss_pkg::cfg_wr_t            cfg_i,
  input  wire logic                        step_i,
  input  wire tss_pkg::func_e              func_i,
  input  wire logic [tss_pkg::TIME_W-1:0]  now_i,
  output tss_pkg::result_t                 result_o
);

  logic [tss_pkg::CFG_DATA_W-1:0] duration_q;
  logic [tss_pkg::CFG_DATA_W-1:0] lamp_count_q;

  logic                           active_q, active_d;
  tss_pkg::phase_e                phase_q, phase_d;
  logic                           brake_q, brake_d;
  logic [tss_pkg::TIME_W-1:0]     start_q, start_d;
  logic [tss_pkg::LAMP_N-1:0]     lamps_q, lamps_d;

  logic [tss_pkg::LAMP_N-1:0]     lamp_en;
  logic [tss_pkg::LAMP_N-1:0]     lamp_set, lamp_clr;
  logic [tss_pkg::TIME_W-1:0]     elapsed;
  logic [tss_pkg::LEN_W-1:0]      phase_len;
  logic                           len_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q   <= '0;
      lamp_count_q <= '0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        tss_pkg::CFG_DURATION:   duration_q   <= cfg_i.data;
        tss_pkg::CFG_LAMP_COUNT: lamp_count_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < tss_pkg::LAMP_N; i++) begin
      lamp_en[i] = (tss_pkg::CFG_DATA_W'(i) < lamp_count_q);
    end
  end

  assign elapsed   = now_i - start_q;
  assign phase_len = tss_pkg::LEN_W'(duration_q) * tss_pkg::PHASE_UNIT_MS;
  assign len_done  = (elapsed >= tss_pkg::TIME_W'(phase_len));

  always_comb begin
    active_d = active_q;
    phase_d  = phase_q;
    brake_d  = brake_q;
    start_d  = start_q;
    lamp_set = '0;
    lamp_clr = '0;
    unique case (func_i)
      tss_pkg::FUNC_ON: begin
        brake_d  = 1'b0;
        phase_d  = tss_pkg::PH_RED;
        start_d  = '0;
        active_d = 1'b1;
      end
      tss_pkg::FUNC_OFF: begin
        brake_d  = 1'b0;
        active_d = 1'b0;
      end
      tss_pkg::FUNC_HEARTBEAT: begin
        if (lamp_count_q != '0) begin
          if (!active_q) begin
            lamp_clr = '1;
          end else begin
            unique case (phase_q)
              tss_pkg::PH_GREEN: begin
                if (brake_q) begin
                  if (elapsed >= tss_pkg::BRAKE_OFF_MS) begin
                    lamp_clr[tss_pkg::LAMP_BRAKE] = 1'b1;
                    brake_d = 1'b0;
                  end
                end else if (len_done) begin
                  lamp_clr[tss_pkg::LAMP_GREEN]  = 1'b1;
                  lamp_set[tss_pkg::LAMP_YELLOW] = 1'b1;
                  phase_d = tss_pkg::PH_YELLOW;
                  start_d = now_i;
                end
              end
              tss_pkg::PH_YELLOW: begin
                if (!brake_q) begin
                  if (elapsed >= tss_pkg::BRAKE_ON_MS &&
                      lamp_count_q > tss_pkg::CFG_DATA_W'(2)) begin
                    lamp_set[tss_pkg::LAMP_BRAKE] = 1'b1;
                    brake_d = 1'b1;
                  end
                end else if (elapsed >= tss_pkg::RED_AFTER_MS) begin
                  lamp_clr[tss_pkg::LAMP_YELLOW] = 1'b1;
                  lamp_set[tss_pkg::LAMP_RED]    = 1'b1;
                  phase_d = tss_pkg::PH_RED;
                  start_d = now_i;
                end
              end
              tss_pkg::PH_RED: begin
                if (len_done) begin
                  lamp_clr[tss_pkg::LAMP_RED]   = 1'b1;
                  lamp_set[tss_pkg::LAMP_GREEN] = 1'b1;
                  phase_d = tss_pkg::PH_GREEN;
                  start_d = now_i;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
    lamps_d = (lamps_q & ~(lamp_clr & lamp_en)) | (lamp_set & lamp_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phase_q  <= tss_pkg::PH_RED;
      brake_q  <= 1'b0;
      start_q  <= '0;
      lamps_q  <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      phase_q  <= phase_d;
      brake_q  <= brake_d;
      start_q  <= start_d;
      lamps_q  <= lamps_d;
    end
  end

  always_comb begin
    result_o.lamps = lamps_d;
    unique case (phase_d)
      tss_pkg::PH_GREEN:  result_o.phase = tss_pkg::PHASE_CODE_GREEN;
      tss_pkg::PH_YELLOW: result_o.phase = tss_pkg::PHASE_CODE_YELLOW;
      default:            result_o.phase = tss_pkg::PHASE_CODE_RED;
    endcase
  end

`ifndef ASSERT_OFF
  a_brake_needs_active: assert property (
    @(posedge clk_i) disable iff (!rst_ni) brake_q |-> active_q)
    else $error("brake flag set while group inactive");

  a_phase_onehot: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $onehot(phase_q))
    else $error("phase register not one-hot");

  a_hold_without_step: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(lamps_q) && $stable(start_q))
    else $error("state moved without a request");

  a_phase_change_stamps: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    step_i && func_i == tss_pkg::FUNC_HEARTBEAT && phase_d != phase_q
    |=> start_q == $past(now_i))
    else $error("phase change did not record its timestamp");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/traffic_signal_sequencer.sv
// ----------------------------------------------------------------------------
// traffic_signal_sequencer
// Model traffic signal: green, yellow, red and brake lamps stepped by
// heartbeat requests carrying a millisecond timestamp.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request per beat; tuser is the command (heartbeat, switch on,
//   switch off), tdata the 32-bit millisecond timestamp.
//   m_axis: one result per request, the lamp states and phase after it.
//   cfg: register writes (duration code, lamp count), always ready; write
//   only while no request is in flight.
//   m_axis_tvalid rises once the request has passed the input register and
//   then the output register. One request per cycle is sustained while m_axis
//   does not stall: an input register feeds the state update, and the result
//   lands in an output register in the same cycle.
//   If m_axis stalls, the output register holds and the input register takes
//   one more request; s_axis_tready then drops until the result is taken.
//   Reset clears the group to inactive, phase red, all lamps dark and both
//   configuration registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_signal_sequencer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [tss_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tss_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [31:0]                     s_axis_tdata,  // [31:0] now_ms
  input  wire logic [1:0]                      s_axis_tuser,  // [1:0] func
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] green_lamp, [1] yellow_lamp, [2] red_lamp, [3] brake_lamp,
  // [5:4] phase, [7:6] zero
  output      logic [7:0]                      m_axis_tdata
);

  logic                         in_valid_q, in_valid_d;
  tss_pkg::func_e               in_func_q;
  logic [tss_pkg::TIME_W-1:0]   in_now_q;
  logic                         out_valid_q, out_valid_d;
  tss_pkg::result_t             out_q;
  tss_pkg::result_t             result;
  tss_pkg::cfg_wr_t             cfg_wr;
  logic                         s_accept, advance, step;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr.we   = cfg_valid_i;
  assign cfg_wr.idx  = cfg_index_i;
  assign cfg_wr.data = cfg_data_i;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_accept || (in_valid_q && !step);
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_func_q <= tss_pkg::func_e'(s_axis_tuser);
      in_now_q  <= s_axis_tdata;
    end
    if (step) begin
      out_q <= result;
    end
  end

  tss_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_wr),
    .step_i   (step),
    .func_i   (in_func_q),
    .now_i    (in_now_q),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.phase, out_q.lamps};

endmodule

`default_nettype wire
